// ===== rtl/idfl_pkg.sv =====
`timescale 1ns / 1ps

package idfl_pkg;

   // pool storage
   localparam int POOL_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

   // field widths
   localparam int ID_W       = 32;
   localparam int IDCOUNT_W  = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [ID_W-1:0]      BASE_ID_RST  = '0;
   localparam logic [IDCOUNT_W-1:0] ID_COUNT_RST = 11'd1024;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_REJECTED  = 2'd2
   } status_type;

   typedef enum logic {
      CMD_GET     = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ID  = 1'b0,
      CSR_ID_COUNT = 1'b1
   } csr_index_type;

   // decision for one item, carried to the result stage
   typedef struct packed {
      logic              get_ok;
      status_type        status;
      logic              from_table;
      logic [ADDR_W-1:0] fallback;
   } dec_type;

   // table access for one item
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

// ===== rtl/idfl_ram.sv =====
`timescale 1ns / 1ps

module idfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/idfl_ctrl.sv =====
`timescale 1ns / 1ps

module idfl_ctrl
   import idfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  command,
   input  logic [ID_W-1:0]       release_id,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output dec_type               dec,
   output ram_req_type           ram_req,
   output logic [ID_W-1:0]       base_id
);

   logic [ID_W-1:0]      base_id_ff;
   logic [IDCOUNT_W-1:0] id_count_ff;
   logic [CNT_W-1:0]     taken_ff, taken_in;
   // high-water mark: entries at or above it were never written
   logic [CNT_W-1:0]     high_ff, high_in;
   logic [CNT_W-1:0]     pool_size;
   logic [ID_W-1:0]      offset;
   logic                 exhausted;
   logic                 rejected;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff  <= BASE_ID_RST;
         id_count_ff <= ID_COUNT_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_ID:  base_id_ff  <= csr_wdata[ID_W-1:0];
            CSR_ID_COUNT: id_count_ff <= csr_wdata[IDCOUNT_W-1:0];
            default:      ;
         endcase
      end
   end

   // clamp the pool to the table depth
   assign pool_size = (32'(id_count_ff) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                           : CNT_W'(id_count_ff);

   assign offset    = release_id - base_id_ff;
   assign exhausted = (taken_ff >= pool_size) || (32'(taken_ff) >= 32'(POOL_DEPTH));
   assign rejected  = (offset >= 32'(pool_size)) || (taken_ff == '0);

   // decide the item and the table access
   always_comb begin
      dec      = '0;
      ram_req  = '0;
      taken_in = taken_ff;
      high_in  = high_ff;

      dec.fallback    = taken_ff[ADDR_W-1:0];
      dec.from_table  = (taken_ff < high_ff);
      ram_req.rd_en   = accept;
      ram_req.rd_addr = taken_ff[ADDR_W-1:0];

      if (command_type'(command) == CMD_GET) begin
         if (exhausted) begin
            dec.status = ST_EXHAUSTED;
         end else begin
            dec.status = ST_OK;
            dec.get_ok = 1'b1;
            taken_in   = taken_ff + CNT_W'(1);
         end
      end else begin
         if (rejected) begin
            dec.status = ST_REJECTED;
         end else begin
            dec.status      = ST_OK;
            taken_in        = taken_ff - CNT_W'(1);
            ram_req.wr_en   = accept;
            ram_req.wr_addr = taken_in[ADDR_W-1:0];
            ram_req.wr_data = offset[ADDR_W-1:0];
         end
      end

      if (taken_in > high_ff) begin
         high_in = taken_in;
      end
   end

   // update the stack pointer and high-water mark on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         taken_ff <= taken_in;
         high_ff  <= high_in;
      end
   end

   assign base_id = base_id_ff;

endmodule

// ===== rtl/id_free_list_allocator_core.sv =====
`timescale 1ns / 1ps

// Identifier allocator over a free-list stack of offsets.
// Request channel (req_*): command 0 gets an identifier, command 1 releases
// req_release_id back to the pool. Result channel (rsp_*): granted_id is the
// identifier handed out on a good get, zero otherwise; status is ok,
// exhausted (get with no identifier left) or rejected (release out of the
// window or with nothing taken).
// Configuration (csr_*): index 0 sets base_id, index 1 sets id_count; write
// only while no item is in flight.
// A result is presented from the result register: the item and the table
// read are registered at the accepting edge, and the result register loads
// from them once the output is free.
// Throughput: one item per cycle while rsp_stall is low, set by the single
// table access and the pointer update done per item.
// While rsp_stall holds a result, one more item fills the middle stage;
// req_stall then stays high until the result is taken, so no item is lost.
// Reset clears the taken count and the high-water mark and restores base_id
// to 0 and id_count to 1024.
// The table needs no clearing pass: entries at or above the high-water mark
// read as their own index.

module id_free_list_allocator_core
   import idfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic signed [ID_W-1:0] req_release_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [ID_W-1:0] rsp_granted_id,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              accept;
   logic              out_free;
   dec_type           dec;
   ram_req_type       ram_req;
   logic [ID_W-1:0]   base_id;
   logic [ADDR_W-1:0] rd_data;
   logic [ADDR_W-1:0] entry;
   logic [ID_W-1:0]   granted;

   logic              s1_valid_ff;
   dec_type           s1_dec_ff;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_granted_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   idfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .release_id (req_release_id),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .dec        (dec),
      .ram_req    (ram_req),
      .base_id    (base_id)
   );

   idfl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // hold the decision while the table read completes; fill when empty or when the result register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (out_free || !s1_valid_ff) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dec_ff <= dec;
      end
   end

   // form the identifier from the table entry
   assign entry   = s1_dec_ff.from_table ? rd_data : s1_dec_ff.fallback;
   assign granted = s1_dec_ff.get_ok ? (base_id + ID_W'(entry)) : '0;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_granted_ff <= granted;
         rsp_status_ff  <= s1_dec_ff.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_granted_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
